### hw/rtl/stbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
// Has no dependencies. Every other file in hw/rtl depends on it.
`default_nettype none

package stbs_pkg;

	localparam int DEPTH_DEF      = 1024;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int INDEX_W = 10;
	localparam int COUNT_W = 11;
	localparam int POS_W   = 11;

	// Operation codes carried in the cmd field
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic wr_en;
		logic start;
		logic rd_en;
		logic step;
		logic out_load;
	} stbs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic range_open;
		logic hit;
		logic out_free;
	} stbs_sts_t;

endpackage

`default_nettype wire

### hw/rtl/stbs_if.sv
// Valid/ready channel interfaces for query items and result items.
// Depends on stbs_pkg for field widths.
`default_nettype none

interface stbs_query_if #(
	parameter int DATA_WIDTH = stbs_pkg::DATA_WIDTH_DEF
);
	logic                                valid;
	logic                                ready;
	logic                                cmd;
	logic [stbs_pkg::INDEX_W-1:0]        entry_index;
	logic signed [DATA_WIDTH-1:0]        data_value;

	modport source (output valid, cmd, entry_index, data_value, input ready);
	modport sink   (input valid, cmd, entry_index, data_value, output ready);
endinterface

interface stbs_result_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [stbs_pkg::POS_W-1:0]    position;

	modport source (output valid, found, position, input ready);
	modport sink   (input valid, found, position, output ready);
endinterface

`default_nettype wire

### hw/rtl/stbs_ctrl.sv
// Search controller: sequences table writes, probe reads, compares and result hand-off.
// Depends on stbs_pkg for the command and status structs.
`default_nettype none

module stbs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_cmd,
	output logic                     in_ready,
	input  wire stbs_pkg::stbs_sts_t sts,
	output stbs_pkg::stbs_cmd_t      cmd
);
	import stbs_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_COMPARE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		cmd.wr_en    = accept && (in_cmd == CMD_WRITE);
		cmd.start    = accept && (in_cmd == CMD_SEARCH);
		cmd.rd_en    = (state_q == ST_PROBE) && sts.range_open;
		cmd.step     = (state_q == ST_COMPARE);
		cmd.out_load = (state_q == ST_FINISH) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (in_cmd == CMD_SEARCH)) state_q <= ST_PROBE;
				end
				ST_PROBE: begin
					// empty range means the key is absent
					state_q <= sts.range_open ? ST_COMPARE : ST_FINISH;
				end
				ST_COMPARE: begin
					state_q <= sts.hit ? ST_FINISH : ST_PROBE;
				end
				ST_FINISH: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/stbs_dp.sv
// Search datapath: table memory, range bounds, key compare and output register.
// Depends on stbs_pkg; driven by stbs_ctrl through command and status structs.
`default_nettype none

module stbs_dp #(
	parameter int DEPTH      = stbs_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = stbs_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [stbs_pkg::COUNT_W-1:0]    cfg_wdata,
	input  wire logic [stbs_pkg::INDEX_W-1:0]    in_index,
	input  wire logic signed [DATA_WIDTH-1:0]    in_data,
	input  wire stbs_pkg::stbs_cmd_t             cmd,
	output stbs_pkg::stbs_sts_t                  sts,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 out_found,
	output logic [stbs_pkg::POS_W-1:0]           out_position
);
	import stbs_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DATA_WIDTH-1:0]        table_mem [DEPTH];
	logic signed [DATA_WIDTH-1:0] rd_data_q;
	logic signed [DATA_WIDTH-1:0] key_q;
	logic [COUNT_W-1:0]           count_q;
	logic [COUNT_W-1:0]           lo_q, hi_q, mid_q;
	logic [COUNT_W-1:0]           mid;
	logic [COUNT_W-1:0]           span_end;
	logic                         found_q;
	logic [POS_W-1:0]             pos_q;
	logic                         out_valid_q;
	logic                         out_found_q;
	logic [POS_W-1:0]             out_pos_q;
	logic                         idx_ok;

	assign idx_ok   = (32'(in_index) < DEPTH);
	assign span_end = (32'(count_q) > DEPTH) ? COUNT_W'(DEPTH) : count_q;
	// floor midpoint of the inclusive range, free of overflow
	assign mid      = lo_q + ((hi_q - COUNT_W'(1) - lo_q) >> 1);

	assign sts.range_open = (lo_q < hi_q);
	assign sts.hit        = (rd_data_q == key_q);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign out_found    = out_found_q;
	assign out_position = out_pos_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en && idx_ok) table_mem[AW'(in_index)] <= in_data;
		if (cmd.rd_en) rd_data_q <= table_mem[AW'(mid)];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q   <= in_data;
			lo_q    <= '0;
			hi_q    <= span_end;
			found_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (cmd.rd_en) mid_q <= mid;
			if (cmd.step) begin
				if (rd_data_q == key_q) begin
					found_q <= 1'b1;
					pos_q   <= POS_W'(mid_q + COUNT_W'(1));
				end else if (rd_data_q > key_q) begin
					hi_q <= mid_q;
				end else begin
					lo_q <= mid_q + COUNT_W'(1);
				end
			end
		end
		if (cmd.out_load) begin
			out_found_q <= found_q;
			out_pos_q   <= pos_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) count_q <= cfg_wdata;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/sorted_table_binary_search.sv
// Top level of the sorted table binary search block: controller plus datapath.
// Depends on stbs_pkg, stbs_if, stbs_ctrl and stbs_dp.
//
//   channel   dir   handshake        payload
//   query     in    valid/ready      cmd, entry_index, data_value
//   result    out   valid/ready      found, position
//   cfg       in    cfg_we           cfg_wdata -> entry_count
//
// A write item is taken in the idle state. A search runs P probes and ends in the
// finish state, P the number of probes (at most floor(log2(entry_count)) + 1,
// so 11 for 1024 entries): each probe is one synchronous table read plus one
// compare state, and a miss ends with one more probe state finding the range empty.
// Reset clears the controller, entry_count and the output valid; table words
// hold garbage until written. A stalled result blocks only the next search
// hand-off; the query side keeps taking items until a search needs the slot.
`default_nettype none

module sorted_table_binary_search #(
	parameter int DEPTH      = stbs_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = stbs_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	stbs_query_if.sink                        query,
	stbs_result_if.source                     result,
	input  wire logic                         cfg_we,
	input  wire logic [stbs_pkg::COUNT_W-1:0] cfg_wdata
);
	import stbs_pkg::*;

	stbs_cmd_t cmd;
	stbs_sts_t sts;

	stbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (query.valid),
		.in_cmd   (query.cmd),
		.in_ready (query.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stbs_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_index     (query.entry_index),
		.in_data      (query.data_value),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.out_found    (result.found),
		.out_position (result.position)
	);

endmodule

`default_nettype wire

### hw/rtl/stbs_checker.sv
// Port-level checks for sorted_table_binary_search, attached with bind.
// Depends on stbs_pkg for codes and widths.
`default_nettype none

module stbs_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       q_valid,
	input wire logic                       q_ready,
	input wire logic                       q_cmd,
	input wire logic                       r_valid,
	input wire logic                       r_ready,
	input wire logic                       r_found,
	input wire logic [stbs_pkg::POS_W-1:0] r_position
);
	import stbs_pkg::*;

	// query ready is low straight after a search transfer, while the search runs
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready && (q_cmd == CMD_SEARCH) |=> !q_ready)
		else $error("query ready right after a search transfer");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_found |-> (r_position == '0))
		else $error("miss result carries a nonzero position");

	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_found |-> (r_position != '0))
		else $error("hit result carries position zero");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_found) && $stable(r_position))
		else $error("stalled result changed or dropped");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.q_valid    (query.valid),
	.q_ready    (query.ready),
	.q_cmd      (query.cmd),
	.r_valid    (result.valid),
	.r_ready    (result.ready),
	.r_found    (result.found),
	.r_position (result.position)
);

`default_nettype wire

### tb/tb.sv
// Testbench for sorted_table_binary_search: table writes and key searches over
// valid/ready channels, each search result predicted from a local table copy.
// Depends on stbs_pkg, stbs_if and the block RTL.

module tb;
	import stbs_pkg::*;

	localparam int TBL_DEPTH     = DEPTH_DEF;
	localparam int ITEM_TARGET   = 1550;
	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_PCT      = 21;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} lookup_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	stbs_query_if #(.DATA_WIDTH(DATA_WIDTH_DEF)) query_ch ();
	stbs_result_if result_ch ();

	sorted_table_binary_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic signed [DATA_WIDTH_DEF-1:0] table_copy [TBL_DEPTH];
	logic [COUNT_W-1:0]               count_copy;
	lookup_t                          pending_lookups [$];
	int                               fail_count = 0;
	int                               items_done = 0;
	int                               stall_cycles = 0;
	int                               tx_idle_pct = IDLE_PCT;
	int                               rx_idle_pct = IDLE_PCT;
	bit                               rx_hold = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic lookup_t lookup_key(input logic signed [DATA_WIDTH_DEF-1:0] key);
		lookup_t res;
		int lo;
		int hi;
		int mid;
		res = '0;
		lo = 0;
		hi = (count_copy > TBL_DEPTH) ? TBL_DEPTH : int'(count_copy);
		while (lo < hi) begin
			mid = lo + (hi - 1 - lo) / 2;
			if (table_copy[mid] == key) begin
				res.found = 1'b1;
				res.position = POS_W'(mid + 1);
				return res;
			end
			if (table_copy[mid] > key)
				hi = mid;
			else
				lo = mid + 1;
		end
		return res;
	endfunction

	// Mostly keys taken from the table, some neighbors, some random words
	function automatic logic signed [DATA_WIDTH_DEF-1:0] pick_key(input int span);
		int r;
		int k;
		r = $urandom_range(99);
		k = $urandom_range(span - 1);
		if (r < 70)
			return table_copy[k];
		if (r < 85)
			return table_copy[k] + (r[0] ? 1 : -1);
		return $urandom();
	endfunction

	task automatic send_item(input logic op, input logic [INDEX_W-1:0] idx,
			input logic signed [DATA_WIDTH_DEF-1:0] val);
		while ($urandom_range(99) < tx_idle_pct) begin
			query_ch.valid <= 1'b0;
			@(posedge clk);
		end
		query_ch.valid       <= 1'b1;
		query_ch.cmd         <= op;
		query_ch.entry_index <= idx;
		query_ch.data_value  <= val;
		do @(posedge clk); while (!query_ch.ready);
		items_done++;
		if (op == CMD_WRITE)
			table_copy[idx] = val;
		else
			pending_lookups.push_back(lookup_key(val));
	endtask

	// Drop valid, drain all results, then cover any trailing write
	task automatic settle();
		query_ch.valid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_entry_count(input logic [COUNT_W-1:0] n);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= n;
		@(posedge clk);
		cfg_we     <= 1'b0;
		count_copy = n;
	endtask

	// Strictly ascending values spread over the whole signed range
	task automatic write_sorted_prefix(input int n);
		longint step_max;
		longint v;
		step_max = 64'h1_0000_0000 / (n + 1);
		v = -64'sd2147483648 + longint'($urandom_range(32'(step_max - 1)));
		for (int i = 0; i < n; i++) begin
			send_item(CMD_WRITE, INDEX_W'(i), DATA_WIDTH_DEF'(v));
			v += 1 + longint'($urandom_range(32'(step_max - 1)));
		end
	endtask

	task automatic test_empty_table();
		set_entry_count('0);
		send_item(CMD_SEARCH, '0, 32'sd0);
		send_item(CMD_SEARCH, '1, 32'sh8000_0000);
		send_item(CMD_SEARCH, INDEX_W'($urandom()), 32'sh7fff_ffff);
	endtask

	task automatic test_small_table();
		logic signed [DATA_WIDTH_DEF-1:0] vals [8];
		vals = '{32'sh8000_0000, -32'sd5, -32'sd1, 32'sd0, 32'sd1, 32'sd7, 32'sd100,
			32'sh7fff_ffff};
		for (int i = 0; i < 8; i++)
			send_item(CMD_WRITE, INDEX_W'(i), vals[i]);
		set_entry_count(COUNT_W'(8));
		send_item(CMD_SEARCH, '0, vals[0]);
		send_item(CMD_SEARCH, '0, vals[2]);
		send_item(CMD_SEARCH, '0, vals[3]);
		send_item(CMD_SEARCH, '0, vals[5]);
		send_item(CMD_SEARCH, '0, vals[7]);
		send_item(CMD_SEARCH, '0, -32'sd2);
		send_item(CMD_SEARCH, '0, 32'sd50);
		send_item(CMD_SEARCH, '0, 32'sh7fff_fffe);
		// single-entry range
		set_entry_count(COUNT_W'(1));
		send_item(CMD_SEARCH, '0, vals[0]);
		send_item(CMD_SEARCH, '0, vals[3]);
	endtask

	// Out-of-order table: one key hits on the probe path, one present key is missed
	task automatic test_unsorted_table();
		logic signed [DATA_WIDTH_DEF-1:0] vals [5];
		vals = '{32'sd10, 32'sd50, 32'sd20, 32'sd40, 32'sd30};
		for (int i = 0; i < 5; i++)
			send_item(CMD_WRITE, INDEX_W'(i), vals[i]);
		set_entry_count(COUNT_W'(5));
		send_item(CMD_SEARCH, '0, 32'sd20);
		send_item(CMD_SEARCH, '0, 32'sd50);
	endtask

	task automatic test_full_table();
		write_sorted_prefix(TBL_DEPTH);
		set_entry_count(COUNT_W'(TBL_DEPTH));
		send_item(CMD_SEARCH, '0, table_copy[0]);
		send_item(CMD_SEARCH, '0, table_copy[TBL_DEPTH-1]);
		repeat (8) send_item(CMD_SEARCH, INDEX_W'($urandom()), pick_key(TBL_DEPTH));
		// count above the table saturates
		set_entry_count('1);
		send_item(CMD_SEARCH, '0, table_copy[TBL_DEPTH-1]);
		repeat (8) send_item(CMD_SEARCH, INDEX_W'($urandom()), pick_key(TBL_DEPTH));
	endtask

	task automatic test_backpressure();
		rx_hold <= 1'b1;
		fork
			begin
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
			repeat (30) send_item(CMD_SEARCH, INDEX_W'($urandom()), pick_key(TBL_DEPTH));
		join
	endtask

	task automatic test_random_phases();
		int phase;
		int r;
		int n;
		int span;
		phase = 0;
		while (items_done < ITEM_TARGET) begin
			tx_idle_pct = (phase >= 3 && phase < 9) ? 0 : IDLE_PCT;
			rx_idle_pct = tx_idle_pct;
			r = $urandom_range(9);
			if (r < 8)
				n = $urandom_range(1, 48);
			else if (r == 8)
				n = $urandom_range(49, TBL_DEPTH);
			else
				n = $urandom_range(TBL_DEPTH + 1, 2047);
			if (n <= 48 && $urandom_range(1) == 1)
				write_sorted_prefix(n);
			set_entry_count(COUNT_W'(n));
			span = (n > TBL_DEPTH) ? TBL_DEPTH : n;
			repeat ($urandom_range(4, 16)) begin
				if ($urandom_range(19) == 0)
					send_item(CMD_WRITE, INDEX_W'($urandom()), $urandom());
				else
					send_item(CMD_SEARCH, INDEX_W'($urandom()), pick_key(span));
			end
			phase++;
		end
		tx_idle_pct = IDLE_PCT;
		rx_idle_pct = IDLE_PCT;
	endtask

	always @(posedge clk)
		result_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin : check_result
		lookup_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (pending_lookups.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, found %0b position %0d", $time,
					result_ch.found, result_ch.position);
			end else begin
				want = pending_lookups.pop_front();
				if (result_ch.found !== want.found) begin
					fail_count++;
					$display("%0t: found mismatch, expected %0b, actual %0b", $time,
						want.found, result_ch.found);
				end
				if (result_ch.position !== want.position) begin
					fail_count++;
					$display("%0t: position mismatch, expected %0d, actual %0d", $time,
						want.position, result_ch.position);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		query_ch.valid       = 1'b0;
		query_ch.cmd         = CMD_WRITE;
		query_ch.entry_index = '0;
		query_ch.data_value  = '0;
		result_ch.ready      = 1'b0;
		count_copy           = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_small_table();
		test_unsorted_table();
		test_full_table();
		test_backpressure();
		test_random_phases();
		settle();
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
